// ===== rtl/core/sesf_pkg.sv =====
// ----------------------------------------------------------------------------
// sesf_pkg: shared types and constants of the smooth end-stop force block
// Register indexes, reset values, field widths and the force/config structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sesf_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LIMIT = 3'd0,
        CFG_UPPER_LIMIT = 3'd1,
        CFG_STIFFNESS   = 3'd2,
        CFG_DAMPING     = 3'd3,
        CFG_SMOOTHNESS  = 3'd4
    } t_cfg_idx;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] RST_LOWER_LIMIT = 32'd0;
    localparam logic [CFG_DATA_W-1:0] RST_UPPER_LIMIT = 32'd16777216;
    localparam logic [CFG_DATA_W-1:0] RST_STIFFNESS   = 32'd0;
    localparam logic [CFG_DATA_W-1:0] RST_DAMPING     = 32'd0;
    localparam logic [CFG_DATA_W-1:0] RST_SMOOTHNESS  = 32'd65536;

    // Field widths.
    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int WGT_W   = 17;
    localparam int FORCE_W = 48;
    localparam int FMAG_W  = 49;

    // Weight of one in Q1.16.
    localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;

    // Product alpha*|y| saturates the weight at and above 2^43.
    localparam int P_W = 43;

    // Q2.30 constants of the logistic table generator.
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint HALF_Q30 = 64'sd536870912;

    // Default logistic table depth.
    localparam int SIG_DEPTH_DEF = 256;

    // Register stages from an accepted transaction to its result.
    localparam int PIPE_DEPTH = 8;

    // Configuration register file contents.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] lower_limit;
        logic [CFG_DATA_W-1:0] upper_limit;
        logic [CFG_DATA_W-1:0] stiffness;
        logic [CFG_DATA_W-1:0] damping;
        logic [CFG_DATA_W-1:0] smoothness;
    } t_cfg;

    // One spring-damper force in sign-magnitude Q.16 form.
    typedef struct packed {
        logic              neg;
        logic [FMAG_W-1:0] mag;
    } t_force;

endpackage

`default_nettype wire

// ===== rtl/core/sesf_cfg.sv =====
// ----------------------------------------------------------------------------
// sesf_cfg: configuration registers
// Holds limits, stiffness, damping and smoothness; written one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sesf_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sesf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sesf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output sesf_pkg::t_cfg                    o_cfg
);
    import sesf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register write decode; unknown indexes leave everything unchanged.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOWER_LIMIT: n_cfg.lower_limit = i_cfg_wdata;
                CFG_UPPER_LIMIT: n_cfg.upper_limit = i_cfg_wdata;
                CFG_STIFFNESS:   n_cfg.stiffness   = i_cfg_wdata;
                CFG_DAMPING:     n_cfg.damping     = i_cfg_wdata;
                CFG_SMOOTHNESS:  n_cfg.smoothness  = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Register file with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_limit <= RST_LOWER_LIMIT;
            r_cfg.upper_limit <= RST_UPPER_LIMIT;
            r_cfg.stiffness   <= RST_STIFFNESS;
            r_cfg.damping     <= RST_DAMPING;
            r_cfg.smoothness  <= RST_SMOOTHNESS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/sesf_force.sv =====
// ----------------------------------------------------------------------------
// sesf_force: spring-damper force pipeline for both limits
// Stages 2..6: magnitudes, products, sums, sign-magnitude forces, alignment.
// ----------------------------------------------------------------------------
`default_nettype none

module sesf_force (
    input  logic                                   i_clk,
    input  logic signed [sesf_pkg::DIFF_W-1:0]     i_d_lo,
    input  logic signed [sesf_pkg::DIFF_W-1:0]     i_d_hi,
    input  logic signed [sesf_pkg::POS_W-1:0]      i_vel,
    input  logic [sesf_pkg::CFG_DATA_W-1:0]        i_stiffness,
    input  logic [sesf_pkg::CFG_DATA_W-1:0]        i_damping,
    output sesf_pkg::t_force                       o_force_lo,
    output sesf_pkg::t_force                       o_force_hi
);
    import sesf_pkg::*;

    // Stage 2: magnitudes and signs.
    logic [DIFF_W-1:0] r_mlo2, r_mhi2;
    logic [POS_W-1:0]  r_vm2;
    logic              r_nlo2, r_nhi2, r_nv2;

    // Stage 3: products reduced to Q.16.
    logic [64:0]       n_plo3, n_phi3;
    logic [63:0]       n_pv3;
    logic [47:0]       r_alo3, r_ahi3;
    logic [46:0]       r_b3;
    logic              r_nlo3, r_nhi3, r_nv3;

    // Stage 4: signed forces.
    logic signed [49:0] n_salo4, n_sahi4, n_sb4;
    logic signed [49:0] r_flo4, r_fhi4;

    // Stage 5 and 6: sign-magnitude forms.
    t_force r_flo5, r_fhi5;
    t_force r_flo6, r_fhi6;

    always_ff @(posedge i_clk) begin
        // Stage 2
        r_mlo2 <= i_d_lo[DIFF_W-1] ? DIFF_W'(-i_d_lo) : DIFF_W'(i_d_lo);
        r_mhi2 <= i_d_hi[DIFF_W-1] ? DIFF_W'(-i_d_hi) : DIFF_W'(i_d_hi);
        r_vm2  <= i_vel[POS_W-1] ? POS_W'(-i_vel) : POS_W'(i_vel);
        r_nlo2 <= i_d_lo[DIFF_W-1];
        r_nhi2 <= i_d_hi[DIFF_W-1];
        r_nv2  <= i_vel[POS_W-1];
        // Stage 3
        r_alo3 <= n_plo3[63:16];
        r_ahi3 <= n_phi3[63:16];
        r_b3   <= n_pv3[62:16];
        r_nlo3 <= r_nlo2;
        r_nhi3 <= r_nhi2;
        r_nv3  <= r_nv2;
        // Stage 4
        r_flo4 <= n_salo4 + n_sb4;
        r_fhi4 <= n_sahi4 + n_sb4;
        // Stage 5
        r_flo5.neg <= r_flo4[49];
        r_flo5.mag <= r_flo4[49] ? FMAG_W'(-r_flo4) : FMAG_W'(r_flo4);
        r_fhi5.neg <= r_fhi4[49];
        r_fhi5.mag <= r_fhi4[49] ? FMAG_W'(-r_fhi4) : FMAG_W'(r_fhi4);
        // Stage 6: align with the weight pipeline.
        r_flo6 <= r_flo5;
        r_fhi6 <= r_fhi5;
    end

    // Stiffness and damping products; magnitudes stay below 2^64 and 2^63.
    always_comb begin
        n_plo3 = 65'(i_stiffness) * 65'(r_mlo2);
        n_phi3 = 65'(i_stiffness) * 65'(r_mhi2);
        n_pv3  = 64'(i_damping) * 64'(r_vm2);
    end

    // Restore signs after truncation toward zero.
    always_comb begin
        n_salo4 = $signed({2'b00, r_alo3});
        n_sahi4 = $signed({2'b00, r_ahi3});
        n_sb4   = $signed({3'b000, r_b3});
        if (r_nlo3) begin
            n_salo4 = -n_salo4;
        end
        if (r_nhi3) begin
            n_sahi4 = -n_sahi4;
        end
        if (r_nv3) begin
            n_sb4 = -n_sb4;
        end
    end

    assign o_force_lo = r_flo6;
    assign o_force_hi = r_fhi6;

endmodule

`default_nettype wire

// ===== rtl/core/sesf_weight.sv =====
// ----------------------------------------------------------------------------
// sesf_weight: logistic activation weight of one limit
// Stages 2..6: |y|, alpha product, table address, lookup, interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module sesf_weight #(
    parameter int SIGMOID_TABLE_DEPTH = sesf_pkg::SIG_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic signed [sesf_pkg::DIFF_W-1:0]  i_y,
    input  logic [sesf_pkg::CFG_DATA_W-1:0]     i_alpha,
    output logic [sesf_pkg::WGT_W-1:0]          o_weight
);
    import sesf_pkg::*;

    localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int TW = $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam int QW = P_W + IW;

    // Constant logistic table, entries 0..DEPTH, built at elaboration.
    logic [WGT_W-1:0] w_tab [SIGMOID_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SIGMOID_TABLE_DEPTH; gi++) begin : g_tab
        localparam longint ARG  = (longint'(gi) << 30) / SIGMOID_TABLE_DEPTH;
        // Truncated Taylor terms of exp(-ARG).
        localparam longint TM01 = ((ONE_Q30 * ARG) >> 30) / 1;
        localparam longint TM02 = ((TM01 * ARG) >> 30) / 2;
        localparam longint TM03 = ((TM02 * ARG) >> 30) / 3;
        localparam longint TM04 = ((TM03 * ARG) >> 30) / 4;
        localparam longint TM05 = ((TM04 * ARG) >> 30) / 5;
        localparam longint TM06 = ((TM05 * ARG) >> 30) / 6;
        localparam longint TM07 = ((TM06 * ARG) >> 30) / 7;
        localparam longint TM08 = ((TM07 * ARG) >> 30) / 8;
        localparam longint TM09 = ((TM08 * ARG) >> 30) / 9;
        localparam longint TM10 = ((TM09 * ARG) >> 30) / 10;
        localparam longint TM11 = ((TM10 * ARG) >> 30) / 11;
        localparam longint TM12 = ((TM11 * ARG) >> 30) / 12;
        localparam longint TM13 = ((TM12 * ARG) >> 30) / 13;
        localparam longint TM14 = ((TM13 * ARG) >> 30) / 14;
        localparam longint TM15 = ((TM14 * ARG) >> 30) / 15;
        localparam longint TM16 = ((TM15 * ARG) >> 30) / 16;
        localparam longint TM17 = ((TM16 * ARG) >> 30) / 17;
        localparam longint TM18 = ((TM17 * ARG) >> 30) / 18;
        localparam longint TM19 = ((TM18 * ARG) >> 30) / 19;
        localparam longint TM20 = ((TM19 * ARG) >> 30) / 20;
        localparam longint SUM  = ONE_Q30 - TM01 + TM02 - TM03 + TM04 - TM05
                                + TM06 - TM07 + TM08 - TM09 + TM10 - TM11
                                + TM12 - TM13 + TM14 - TM15 + TM16 - TM17
                                + TM18 - TM19 + TM20;
        // Clamp at zero, then raise to the 16th power by four squarings.
        localparam longint E0   = (SUM < 0) ? 64'sd0 : SUM;
        localparam longint E1   = (E0 * E0 + HALF_Q30) >> 30;
        localparam longint E2   = (E1 * E1 + HALF_Q30) >> 30;
        localparam longint E3   = (E2 * E2 + HALF_Q30) >> 30;
        localparam longint E4   = (E3 * E3 + HALF_Q30) >> 30;
        localparam longint DEN  = ONE_Q30 + E4;
        localparam longint ENT  = ((64'sd1 << 46) + DEN / 2) / DEN;
        assign w_tab[gi] = WGT_W'(ENT);
    end

    // Stage 2: magnitude and sign of y.
    logic [DIFF_W-1:0] r_mag2;
    logic              r_neg2;

    // Stage 3: alpha*|y| and its saturation flag.
    logic [64:0]       n_prod3;
    logic [P_W-1:0]    r_p3;
    logic              r_sat3, r_neg3;

    // Stage 4: table index and fraction.
    logic [QW-1:0]     n_q4;
    logic [IW-1:0]     r_idx4;
    logic [15:0]       r_frac4;
    logic              r_sat4, r_neg4;

    // Stage 5: the two neighboring table entries.
    logic [WGT_W-1:0]  r_t0_5, r_t1_5;
    logic [15:0]       r_frac5;
    logic              r_sat5, r_neg5;

    // Stage 6: interpolated weight.
    logic [32:0]       n_acc6;
    logic [WGT_W-1:0]  n_s6, n_w6, r_w6;

    always_ff @(posedge i_clk) begin
        // Stage 2
        r_mag2  <= i_y[DIFF_W-1] ? DIFF_W'(-i_y) : DIFF_W'(i_y);
        r_neg2  <= i_y[DIFF_W-1];
        // Stage 3
        r_p3    <= n_prod3[P_W-1:0];
        r_sat3  <= |n_prod3[64:P_W];
        r_neg3  <= r_neg2;
        // Stage 4
        r_idx4  <= n_q4[QW-1:P_W];
        r_frac4 <= n_q4[P_W-1:P_W-16];
        r_sat4  <= r_sat3;
        r_neg4  <= r_neg3;
        // Stage 5
        r_t0_5  <= w_tab[TW'(r_idx4)];
        r_t1_5  <= w_tab[TW'(r_idx4) + TW'(1)];
        r_frac5 <= r_frac4;
        r_sat5  <= r_sat4;
        r_neg5  <= r_neg4;
        // Stage 6
        r_w6    <= n_w6;
    end

    // Scaled argument and table position.
    always_comb begin
        n_prod3 = 65'(i_alpha) * 65'(r_mag2);
        n_q4    = QW'(r_p3) * QW'(SIGMOID_TABLE_DEPTH);
    end

    // Linear interpolation with rounding, saturation and mirroring for y < 0.
    always_comb begin
        n_acc6 = 33'(r_t0_5) * 33'(WGT_ONE - WGT_W'(r_frac5))
               + 33'(r_t1_5) * 33'(r_frac5) + 33'd32768;
        n_s6   = r_sat5 ? WGT_ONE : n_acc6[32:16];
        n_w6   = r_neg5 ? WGT_ONE - n_s6 : n_s6;
    end

    assign o_weight = r_w6;

endmodule

`default_nettype wire

// ===== rtl/core/sesf_blend.sv =====
// ----------------------------------------------------------------------------
// sesf_blend: weighting, summation and saturation of the two stop forces
// Stage 7 scales each force by its weight; stage 8 adds and clips the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sesf_blend (
    input  logic                                i_clk,
    input  sesf_pkg::t_force                    i_force_lo,
    input  sesf_pkg::t_force                    i_force_hi,
    input  logic [sesf_pkg::WGT_W-1:0]          i_w_lo,
    input  logic [sesf_pkg::WGT_W-1:0]          i_w_hi,
    output logic signed [sesf_pkg::FORCE_W-1:0] o_net_force,
    output logic [sesf_pkg::WGT_W-1:0]          o_lower_weight,
    output logic [sesf_pkg::WGT_W-1:0]          o_upper_weight,
    output logic                                o_force_saturated
);
    import sesf_pkg::*;

    localparam int RW = 50;
    localparam int SW = 52;
    localparam logic signed [SW-1:0] SUM_MAX = 52'sd140737488355327;
    localparam logic signed [SW-1:0] SUM_MIN = -52'sd140737488355328;

    // Force magnitude times weight, truncated to Q.16.
    function automatic logic [RW-1:0] f_weigh(input logic [FMAG_W-1:0] mag,
                                              input logic [WGT_W-1:0] w);
        logic [RW-1:0] hi_part;
        logic [32:0]   lo_part;
        hi_part = RW'(mag[FMAG_W-1:16]) * RW'(w);
        lo_part = 33'(mag[15:0]) * 33'(w);
        return hi_part + RW'(lo_part[32:16]);
    endfunction

    // Stage 7 registers.
    logic [RW-1:0]    r_rlo7, r_rhi7;
    logic             r_nlo7, r_nhi7;
    logic [WGT_W-1:0] r_wlo7, r_whi7;

    // Stage 8 logic and registers.
    logic signed [SW-1:0]  n_slo8, n_shi8, n_sum8;
    logic signed [FORCE_W-1:0] n_force8, r_force8;
    logic                  n_sat8, r_sat8;
    logic [WGT_W-1:0]      r_wlo8, r_whi8;

    always_ff @(posedge i_clk) begin
        // Stage 7
        r_rlo7   <= f_weigh(i_force_lo.mag, i_w_lo);
        r_rhi7   <= f_weigh(i_force_hi.mag, i_w_hi);
        r_nlo7   <= i_force_lo.neg;
        r_nhi7   <= i_force_hi.neg;
        r_wlo7   <= i_w_lo;
        r_whi7   <= i_w_hi;
        // Stage 8
        r_force8 <= n_force8;
        r_sat8   <= n_sat8;
        r_wlo8   <= r_wlo7;
        r_whi8   <= r_whi7;
    end

    // Signed sum of the weighted forces, clipped to the output range.
    always_comb begin
        n_slo8 = $signed(SW'(r_rlo7));
        n_shi8 = $signed(SW'(r_rhi7));
        if (r_nlo7) begin
            n_slo8 = -n_slo8;
        end
        if (r_nhi7) begin
            n_shi8 = -n_shi8;
        end
        n_sum8 = n_slo8 + n_shi8;
        if (n_sum8 > SUM_MAX) begin
            n_force8 = FORCE_W'(SUM_MAX);
            n_sat8   = 1'b1;
        end else if (n_sum8 < SUM_MIN) begin
            n_force8 = FORCE_W'(SUM_MIN);
            n_sat8   = 1'b1;
        end else begin
            n_force8 = FORCE_W'(n_sum8);
            n_sat8   = 1'b0;
        end
    end

    assign o_net_force       = r_force8;
    assign o_force_saturated = r_sat8;
    assign o_lower_weight    = r_wlo8;
    assign o_upper_weight    = r_whi8;

endmodule

`default_nettype wire

// ===== rtl/core/smooth_end_stop_force.sv =====
// ----------------------------------------------------------------------------
// smooth_end_stop_force: blended spring-damper end-stop force
// Top level: input stage, valid pipeline and the four datapath units.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on a rising edge with i_start high and o_busy
//   low; o_busy is always low, so a new position/velocity pair can be given
//   in every cycle. Each transaction yields exactly one result, presented for
//   one cycle with o_done high. Results come out in acceptance order and are
//   never held back; the receiver cannot stall, and none is needed, as every
//   stage advances on every clock.
//   The eight stages are: operand differences, magnitudes, the 32x33 and
//   32x32 bit products, force sums and table address, table lookup and force
//   magnitudes, interpolation, force weighting, and the final saturating sum.
//   Throughput is one transaction per cycle, set by the fully pipelined
//   multiplier stages.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/
//   i_cfg_wdata and must only change while no transaction is in flight.
//   A synchronous reset (i_rst_n low) restores register defaults and drops
//   every transaction in flight; no result strobes after it.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_end_stop_force #(
    parameter int SIGMOID_TABLE_DEPTH = sesf_pkg::SIG_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [sesf_pkg::POS_W-1:0]   i_position,
    input  logic signed [sesf_pkg::POS_W-1:0]   i_velocity,
    input  logic                                i_cfg_we,
    input  logic [sesf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sesf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_done,
    output logic signed [sesf_pkg::FORCE_W-1:0] o_net_force,
    output logic [sesf_pkg::WGT_W-1:0]          o_lower_weight,
    output logic [sesf_pkg::WGT_W-1:0]          o_upper_weight,
    output logic                                o_force_saturated
);
    import sesf_pkg::*;

    t_cfg                    w_cfg;
    logic                    w_busy;
    logic                    w_accept;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic signed [DIFF_W-1:0] r_d_lo, r_d_hi;
    logic signed [POS_W-1:0] r_vel;
    logic signed [DIFF_W-1:0] w_y_lo;
    t_force                  w_force_lo, w_force_hi;
    logic [WGT_W-1:0]        w_w_lo, w_w_hi;

    // The pipeline never blocks a new transaction.
    assign w_busy   = 1'b0;
    assign w_accept = i_start & ~w_busy;

    sesf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Valid bits travel alongside the datapath stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    // Stage 1: distances to both limits.
    always_ff @(posedge i_clk) begin
        r_d_lo <= $signed({i_position[POS_W-1], i_position})
                - $signed({w_cfg.lower_limit[POS_W-1], w_cfg.lower_limit});
        r_d_hi <= $signed({i_position[POS_W-1], i_position})
                - $signed({w_cfg.upper_limit[POS_W-1], w_cfg.upper_limit});
        r_vel  <= i_velocity;
    end

    // The lower stop activates as the position drops below its limit.
    assign w_y_lo = -r_d_lo;

    sesf_force u_force (
        .i_clk       (i_clk),
        .i_d_lo      (r_d_lo),
        .i_d_hi      (r_d_hi),
        .i_vel       (r_vel),
        .i_stiffness (w_cfg.stiffness),
        .i_damping   (w_cfg.damping),
        .o_force_lo  (w_force_lo),
        .o_force_hi  (w_force_hi)
    );

    sesf_weight #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_weight_lo (
        .i_clk    (i_clk),
        .i_y      (w_y_lo),
        .i_alpha  (w_cfg.smoothness),
        .o_weight (w_w_lo)
    );

    sesf_weight #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_weight_hi (
        .i_clk    (i_clk),
        .i_y      (r_d_hi),
        .i_alpha  (w_cfg.smoothness),
        .o_weight (w_w_hi)
    );

    sesf_blend u_blend (
        .i_clk             (i_clk),
        .i_force_lo        (w_force_lo),
        .i_force_hi        (w_force_hi),
        .i_w_lo            (w_w_lo),
        .i_w_hi            (w_w_hi),
        .o_net_force       (o_net_force),
        .o_lower_weight    (o_lower_weight),
        .o_upper_weight    (o_upper_weight),
        .o_force_saturated (o_force_saturated)
    );

    assign o_busy = w_busy;
    assign o_done = r_vld[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/sesf_checker.sv =====
// ----------------------------------------------------------------------------
// sesf_checker: port-level checks of the smooth end-stop force block
// Latency, reset behavior, weight range and saturation consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module sesf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_start,
    input logic                                o_busy,
    input logic                                o_done,
    input logic signed [sesf_pkg::FORCE_W-1:0] o_net_force,
    input logic [sesf_pkg::WGT_W-1:0]          o_lower_weight,
    input logic [sesf_pkg::WGT_W-1:0]          o_upper_weight,
    input logic                                o_force_saturated
);
    import sesf_pkg::*;

    // Every accepted transaction yields its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##PIPE_DEPTH o_done)
        else $error("result missing after accepted transaction");

    // No result appears without a transaction accepted one latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, PIPE_DEPTH))
        else $error("result strobe without matching transaction");

    // Reset drops everything in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // Weights never exceed one.
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_lower_weight <= WGT_ONE) && (o_upper_weight <= WGT_ONE))
        else $error("weight above one");

    // A clipped force sits exactly at one end of the output range.
    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_force_saturated) |->
            (o_net_force == 48'sh7FFF_FFFF_FFFF) ||
            (o_net_force == 48'sh8000_0000_0000))
        else $error("saturation flag without clipped force");

endmodule

bind smooth_end_stop_force sesf_checker u_sesf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .o_done            (o_done),
    .o_net_force       (o_net_force),
    .o_lower_weight    (o_lower_weight),
    .o_upper_weight    (o_upper_weight),
    .o_force_saturated (o_force_saturated)
);

`default_nettype wire
